[hw/rtl/dnsq_pkg.sv]
// ----------------------------------------------------------------------------
// DNS question decoder package
// Shared types, codes and constants of the DNS question decoder.
// ----------------------------------------------------------------------------
package dnsq_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD16_W = 16;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned ERR_W   = 2;
   localparam int unsigned LABEL_W = 6;
   localparam int unsigned SEEN_W  = 3;

   localparam logic [BYTE_W-1:0]  MAX_LABEL_LEN  = 8'd63;
   localparam logic [BYTE_W-1:0]  DOT_CHAR       = 8'h2E;
   localparam logic [BYTE_W-1:0]  UPPER_A        = 8'h41;
   localparam logic [BYTE_W-1:0]  UPPER_Z        = 8'h5A;
   localparam logic [BYTE_W-1:0]  CASE_OFFSET    = 8'h20;
   localparam logic [SEEN_W-1:0]  SEEN_SATURATE  = 3'd5;
   localparam logic [SEEN_W-1:0]  MIN_BODY_BYTES = 3'd4;

   localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_SHORT = 2'd1;
   localparam logic [ERR_W-1:0] ERR_TRUNC = 2'd2;
   localparam logic [ERR_W-1:0] ERR_LONG  = 2'd3;

   typedef enum logic [2:0] {
      PH_FIRST_LEN = 3'd0,
      PH_LABEL     = 3'd1,
      PH_NEXT_LEN  = 3'd2,
      PH_TYPE_HI   = 3'd3,
      PH_TYPE_LO   = 3'd4,
      PH_CLASS_HI  = 3'd5,
      PH_CLASS_LO  = 3'd6,
      PH_SKIP      = 3'd7
   } parse_phase_type;

   typedef struct packed {
      logic [KIND_W-1:0]   result_kind;
      logic [BYTE_W-1:0]   name_char;
      logic [WORD16_W-1:0] query_type;
      logic [WORD16_W-1:0] query_class;
      logic [ERR_W-1:0]    error_code;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } parse_result_type;

endpackage

[hw/rtl/dnsq_if.sv]
// ----------------------------------------------------------------------------
// DNS question decoder channels
// Valid/ready channels for the byte input and the result output.
// ----------------------------------------------------------------------------
interface dnsq_req_if;
   import dnsq_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface dnsq_rsp_if;
   import dnsq_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   result_kind;
   logic [BYTE_W-1:0]   name_char;
   logic [WORD16_W-1:0] query_type;
   logic [WORD16_W-1:0] query_class;
   logic [ERR_W-1:0]    error_code;

   modport source (
      output valid, output result_kind, output name_char, output query_type,
      output query_class, output error_code, input ready
   );
   modport sink (
      input valid, input result_kind, input name_char, input query_type,
      input query_class, input error_code, output ready
   );
endinterface

[hw/rtl/dnsq_parser.sv]
// ----------------------------------------------------------------------------
// DNS question parser
// Parse state registers and the per-byte decode of labels, type and class.
// ----------------------------------------------------------------------------
module dnsq_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [dnsq_pkg::BYTE_W-1:0] data_byte,
   input  logic                       is_last,
   output dnsq_pkg::parse_result_type result
);
   import dnsq_pkg::*;

   parse_phase_type      phase_ff, phase_in;
   logic [LABEL_W-1:0]   remain_ff, remain_in;
   logic [SEEN_W-1:0]    seen_ff, seen_in;
   logic [WORD16_W-1:0]  type_ff, type_in;
   logic [BYTE_W-1:0]    class_hi_ff, class_hi_in;

   logic                 have;
   logic                 done;
   logic                 too_long;
   rsp_word_type         word;
   logic [LABEL_W-1:0]   remain_dec;
   logic [ERR_W-1:0]     err;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIRST_LEN;
         remain_ff   <= '0;
         seen_ff     <= '0;
         type_ff     <= '0;
         class_hi_ff <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         remain_ff   <= remain_in;
         seen_ff     <= seen_in;
         type_ff     <= type_in;
         class_hi_ff <= class_hi_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      remain_in   = remain_ff;
      type_in     = type_ff;
      class_hi_in = class_hi_ff;
      seen_in     = (seen_ff < SEEN_SATURATE) ? seen_ff + 3'd1 : seen_ff;
      have        = 1'b0;
      done        = 1'b0;
      too_long    = 1'b0;
      remain_dec  = remain_ff - 6'd1;
      word        = '0;

      case (phase_ff)
         PH_FIRST_LEN, PH_NEXT_LEN: begin
            if (data_byte > MAX_LABEL_LEN) begin
               too_long = 1'b1;
               phase_in = PH_SKIP;
            end else if (data_byte == '0) begin
               phase_in = PH_TYPE_HI;
            end else begin
               remain_in = data_byte[LABEL_W-1:0];
               phase_in  = PH_LABEL;
               if (phase_ff == PH_NEXT_LEN) begin
                  have             = 1'b1;
                  word.result_kind = KIND_CHAR;
                  word.name_char   = DOT_CHAR;
               end
            end
         end
         PH_LABEL: begin
            have             = 1'b1;
            word.result_kind = KIND_CHAR;
            word.name_char   = (data_byte >= UPPER_A && data_byte <= UPPER_Z)
                               ? data_byte + CASE_OFFSET : data_byte;
            remain_in        = remain_dec;
            if (remain_dec == '0) begin
               phase_in = PH_NEXT_LEN;
            end
         end
         PH_TYPE_HI: begin
            type_in  = {data_byte, 8'h00};
            phase_in = PH_TYPE_LO;
         end
         PH_TYPE_LO: begin
            type_in  = {type_ff[WORD16_W-1:BYTE_W], data_byte};
            phase_in = PH_CLASS_HI;
         end
         PH_CLASS_HI: begin
            class_hi_in = data_byte;
            phase_in    = PH_CLASS_LO;
         end
         PH_CLASS_LO: begin
            have             = 1'b1;
            done             = 1'b1;
            word.result_kind = KIND_DONE;
            word.query_type  = type_ff;
            word.query_class = {class_hi_ff, data_byte};
            phase_in         = PH_SKIP;
         end
         default: begin
         end
      endcase

      if (seen_in <= MIN_BODY_BYTES) begin
         err = ERR_SHORT;
      end else if (too_long) begin
         err = ERR_LONG;
      end else begin
         err = ERR_TRUNC;
      end

      result.valid = have;
      result.word  = word;
      if (is_last) begin
         if (phase_ff != PH_SKIP && !done) begin
            result.valid            = 1'b1;
            result.word             = '0;
            result.word.result_kind = KIND_ERROR;
            result.word.error_code  = err;
         end
         phase_in    = PH_FIRST_LEN;
         remain_in   = '0;
         seen_in     = '0;
         type_in     = '0;
         class_hi_in = '0;
      end else if (too_long) begin
         result.valid            = 1'b1;
         result.word             = '0;
         result.word.result_kind = KIND_ERROR;
         result.word.error_code  = ERR_LONG;
      end
   end

endmodule

[hw/rtl/dnsq_out_reg.sv]
// ----------------------------------------------------------------------------
// DNS question decoder result register
// Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module dnsq_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  dnsq_pkg::rsp_word_type word,
   output logic                   free,
   dnsq_rsp_if.source             rsp
);
   import dnsq_pkg::*;

   logic         valid_ff;
   rsp_word_type word_ff;

   assign free = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) begin
         word_ff <= word;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.result_kind = word_ff.result_kind;
   assign rsp.name_char   = word_ff.name_char;
   assign rsp.query_type  = word_ff.query_type;
   assign rsp.query_class = word_ff.query_class;
   assign rsp.error_code  = word_ff.error_code;

endmodule

[hw/rtl/dns_question_decoder.sv]
// ----------------------------------------------------------------------------
// DNS question decoder
// Path: a byte word is held in the input register, decoded by the combinational
// parser, and its result word, if any, is loaded into the result register.
// Throughput: one byte word per cycle; the input register refills as its byte
// word is parsed, so only a stalled result register holds input back.
// Reset clears the parse state and empties the input and result registers.
// ----------------------------------------------------------------------------
module dns_question_decoder (
   input  logic     clock,
   input  logic     reset,
   dnsq_req_if.sink req,
   dnsq_rsp_if.source rsp
);
   import dnsq_pkg::*;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              out_free;
   logic              step;
   parse_result_type  result;

   assign step      = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.data_byte;
         in_last_ff <= req.is_last;
      end
   end

   dnsq_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .is_last   (in_last_ff),
      .result    (result)
   );

   dnsq_out_reg u_out_reg (
      .clock (clock),
      .reset (reset),
      .load  (step && result.valid),
      .word  (result.word),
      .free  (out_free),
      .rsp   (rsp)
   );

   // A waiting byte word is held while the result register is stalled.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |-> !req.ready)
      else $error("input accepted while a byte word waits");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_kind == KIND_ERROR |->
         rsp.error_code != ERR_NONE && rsp.name_char == '0)
      else $error("error word without a code");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.result_kind == KIND_CHAR || rsp.result_kind == KIND_DONE ||
         rsp.result_kind == KIND_ERROR)
      else $error("undefined result kind");

   a_load_ok: assert property (@(posedge clock) disable iff (reset)
      step && result.valid |=> rsp.valid)
      else $error("result lost on load");

endmodule
